FILE: hdl/gf2m_power_macros.svh
// Assertion macros shared by the gf2m_power RTL.
// Needs clock i_clk and synchronous active-low reset i_rst_n in the including scope.
`ifndef GF2M_POWER_MACROS_SVH
`define GF2M_POWER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GFP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define GFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/gfp_pkg.sv
// Package for gf2m_power: widths, controller/datapath interface types,
// primitive polynomial list and the per-degree reduction table. No dependencies.
package gfp_pkg;

    localparam int GFP_MAX_DEGREE = 16;
    localparam int GFP_W          = 16;
    localparam int GFP_EXP_W      = 31;
    localparam int GFP_DEG_W      = 5;
    localparam int GFP_PROD_W     = 2 * GFP_W - 1;
    localparam logic [GFP_DEG_W-1:0] GFP_DEG_RESET = 5'd13;

    typedef struct packed {
        logic load;   // take a new request into the datapath
        logic step;   // process one exponent bit
        logic emit;   // copy the finished result to the output register
    } t_dp_cmd;

    typedef struct packed {
        logic exp_zero;  // no exponent bits left to process
    } t_dp_sts;

    // Rows: x^j mod p(x) for j over the full carry-less product width.
    typedef logic [GFP_PROD_W-1:0][GFP_W-1:0] t_red;
    typedef logic [GFP_W:0][GFP_PROD_W-1:0][GFP_W-1:0] t_red_tab;

    function automatic logic [GFP_W:0] gfp_poly(input int d);
        logic [GFP_W:0] p;
        case (d)
            2:       p = 17'o7;
            3:       p = 17'o13;
            4:       p = 17'o23;
            5:       p = 17'o45;
            6:       p = 17'o103;
            7:       p = 17'o203;
            8:       p = 17'o435;
            9:       p = 17'o1041;
            10:      p = 17'o2011;
            11:      p = 17'o4005;
            12:      p = 17'o10123;
            13:      p = 17'o20033;
            14:      p = 17'o42103;
            15:      p = 17'o100003;
            16:      p = 17'o210013;
            default: p = '0;
        endcase
        return p;
    endfunction

    // Evaluated once at elaboration to build the constant table.
    function automatic t_red_tab gfp_red_tab();
        t_red_tab       tab;
        logic [GFP_W:0] v;
        logic [GFP_W:0] p;
        for (int d = 0; d <= GFP_W; d++) begin
            p = gfp_poly(d);
            v = 17'd1;
            for (int j = 0; j < GFP_PROD_W; j++) begin
                tab[d][j] = (d >= 2) ? v[GFP_W-1:0] : '0;
                v = v << 1;
                if (d >= 2 && v[d]) begin
                    v = v ^ p;
                end
            end
        end
        return tab;
    endfunction

    localparam t_red_tab GFP_RED_TAB = gfp_red_tab();

    // Field product: carry-less multiply, then fold every product bit through its row.
    function automatic logic [GFP_W-1:0] gfp_mul(input logic [GFP_W-1:0] a,
                                                 input logic [GFP_W-1:0] b,
                                                 input t_red red);
        logic [GFP_PROD_W-1:0] prod;
        logic [GFP_W-1:0]      res;
        prod = '0;
        res  = '0;
        for (int k = 0; k < GFP_PROD_W; k++) begin
            for (int i = 0; i < GFP_W; i++) begin
                if (k >= i && k - i < GFP_W) begin
                    prod[k] = prod[k] ^ (a[i] & b[k-i]);
                end
            end
        end
        for (int j = 0; j < GFP_PROD_W; j++) begin
            if (prod[j]) begin
                res = res ^ red[j];
            end
        end
        return res;
    endfunction

endpackage

FILE: hdl/gf2m_power.sv
// Top level of gf2m_power: exponentiation in GF(2^m), m = 2..16.
// Instantiates gfp_ctrl and gfp_dp; depends on gfp_pkg.
//
//  Channel  | Direction | Handshake                    | Content
//  ---------+-----------+------------------------------+---------------------------
//  input    | in        | i_in_valid / o_in_stall      | i_base, i_exponent
//  output   | out       | o_out_valid / i_out_stall    | o_power
//  config   | in        | i_cfg_valid / o_cfg_ready    | i_cfg_data (field degree)
//
// A request passes from acceptance to the next acceptance through a load step, a
// step for each exponent bit in the square-and-multiply loop, and a step that moves the
// result into the output register, which waits while a held result still occupies it.
// The loop pairs a squaring unit with a multiplying unit that handle each exponent bit together.
// Reset sets the field degree to 13 and empties the output register.
// A stalled result waits in the output register; the next request is still taken in,
// and only its own completion waits for the register to free.
// A degree outside 2..MAX_DEGREE is clamped; base bits at and above m are dropped.
module gf2m_power
    import gfp_pkg::*;
#(
    parameter int MAX_DEGREE = GFP_MAX_DEGREE
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [GFP_W-1:0]     i_base,
    input  logic [GFP_EXP_W-1:0] i_exponent,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [GFP_W-1:0]     o_power,
    // configuration channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [GFP_DEG_W-1:0] i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // the degree register always takes a write
    assign o_cfg_ready = 1'b1;

    gfp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    gfp_dp #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_base     (i_base),
        .i_exponent (i_exponent),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_power    (o_power)
    );

endmodule

FILE: hdl/gfp_ctrl.sv
// Controller for gf2m_power: request sequencing and output register valid.
// Depends on gfp_pkg and gf2m_power_macros.svh.
`include "gf2m_power_macros.svh"

module gfp_ctrl
    import gfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic {ST_IDLE, ST_RUN} t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    always_comb begin
        out_free     = !r_out_valid || !i_out_stall;
        o_cmd.load   = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.step   = (r_state == ST_RUN) && !i_sts.exp_zero;
        o_cmd.emit   = (r_state == ST_RUN) && i_sts.exp_zero && out_free;

        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.load) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (o_cmd.emit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // drop valid once taken, raise it on a new result
        n_out_valid = r_out_valid && i_out_stall;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    `GFP_ASSERT_IMPL(a_no_overwrite, r_out_valid && i_out_stall, !o_cmd.emit, "held result lost")
    `GFP_ASSERT_NEXT(a_load_runs, o_cmd.load, r_state == ST_RUN, "accepted request not running")
    `GFP_ASSERT_NEXT(a_emit_valid, o_cmd.emit, r_out_valid, "emitted result not presented")

endmodule

FILE: hdl/gfp_dp.sv
// Datapath for gf2m_power: degree register, right-to-left square-and-multiply
// with a squaring unit and a multiplying unit, output register. Depends on gfp_pkg.
`include "gf2m_power_macros.svh"

module gfp_dp
    import gfp_pkg::*;
#(
    parameter int MAX_DEGREE = GFP_MAX_DEGREE
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [GFP_DEG_W-1:0] i_cfg_data,
    input  logic [GFP_W-1:0]     i_base,
    input  logic [GFP_EXP_W-1:0] i_exponent,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    output logic [GFP_W-1:0]     o_power
);

    localparam int TOP = (MAX_DEGREE < GFP_W) ? MAX_DEGREE : GFP_W;

    logic [GFP_DEG_W-1:0] r_field_degree;
    logic [GFP_DEG_W-1:0] deg;
    logic [GFP_W:0]       mask_full;
    logic [GFP_W-1:0]     mask;

    t_red                 r_red;
    logic [GFP_W-1:0]     r_acc, r_sq, r_power;
    logic [GFP_EXP_W-1:0] r_exp;
    logic [GFP_W-1:0]     mul_out, sq_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_degree <= GFP_DEG_RESET;
        end else if (i_cfg_we) begin
            r_field_degree <= i_cfg_data;
        end
    end

    // clamp the degree into the supported range
    always_comb begin
        if (r_field_degree < GFP_DEG_W'(2)) begin
            deg = GFP_DEG_W'(2);
        end else if (r_field_degree > GFP_DEG_W'(TOP)) begin
            deg = GFP_DEG_W'(TOP);
        end else begin
            deg = r_field_degree;
        end
        mask_full = ((GFP_W+1)'(1) << deg) - (GFP_W+1)'(1);
        mask      = mask_full[GFP_W-1:0];
    end

    assign mul_out = gfp_mul(r_acc, r_sq, r_red);
    assign sq_out  = gfp_mul(r_sq, r_sq, r_red);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_red <= GFP_RED_TAB[deg];
            r_acc <= GFP_W'(1);
            r_sq  <= i_base & mask;
            r_exp <= i_exponent;
        end else if (i_cmd.step) begin
            if (r_exp[0]) begin
                r_acc <= mul_out;
            end
            r_sq  <= sq_out;
            r_exp <= r_exp >> 1;
        end
        if (i_cmd.emit) begin
            r_power <= r_acc;
        end
    end

    assign o_sts.exp_zero = (r_exp == '0);
    assign o_power        = r_power;

    `GFP_ASSERT_IMPL(a_step_live, i_cmd.step, !o_sts.exp_zero, "step with no exponent bits left")
    `GFP_ASSERT_NEXT(a_emit_copy, i_cmd.emit, r_power == $past(r_acc), "result not captured")

endmodule
